### design/srtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtw_pkg
// Shared types, codes and ripple constants of the sine ripple texture warp.
// ----------------------------------------------------------------------------
package srtw_pkg;

   localparam int FLAT_TEXELS = 4096;
   localparam int ADDR_W      = $clog2(FLAT_TEXELS);
   localparam int COORD_W     = 6;
   localparam int PHASE_W     = 13;
   localparam int TEXEL_W     = 8;
   localparam int TICK_W      = 10;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 8;

   // operation codes carried in req_tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // per-term tick rates and phase bases
   localparam int TICK_RATE_X0 = 200;
   localparam int TICK_RATE_X1 = 160;
   localparam int TICK_RATE_Y0 = 120;
   localparam int TICK_RATE_Y1 = 160;
   localparam int PHASE_BASE_X0 = 900;
   localparam int PHASE_BASE_X1 = 300;
   localparam int PHASE_BASE_Y0 = 700;
   localparam int PHASE_BASE_Y1 = 1200;

   // band edges of floor(2*sin) over the 13-bit phase circle
   localparam int POS_LO  = 683;
   localparam int POS_HI  = 3412;
   localparam int HALF    = 4096;
   localparam int NEG2_LO = 4779;
   localparam int NEG2_HI = 7508;

   typedef logic signed [1:0] ripple_type;

   // floor(2*sin(phase)) as an offset in -2..1
   function automatic ripple_type ripple_term(input logic [PHASE_W-1:0] phase);
      ripple_type r;
      if (phase >= PHASE_W'(POS_LO) && phase <= PHASE_W'(POS_HI)) begin
         r = 2'sd1;
      end else if (phase < PHASE_W'(HALF)) begin
         r = 2'sd0;
      end else if (phase >= PHASE_W'(NEG2_LO) && phase <= PHASE_W'(NEG2_HI)) begin
         r = -2'sd2;
      end else begin
         r = -2'sd1;
      end
      return r;
   endfunction

endpackage

### design/srtw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtw_ram
// Single-port RAM with registered read; read data holds when not enabled.
// ----------------------------------------------------------------------------
module srtw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/sine_ripple_texture_warp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_ripple_texture_warp_core
// Warps a 64x64 byte texture with a two-dimensional sine ripple.
// ----------------------------------------------------------------------------
// Usage:
//   Send beats on the req_ channel. req_tuser selects the operation: a load
//   writes req texel_value at pixel_index into the texture store and returns
//   nothing; a read names destination pixel y*64+x and a frame tick and
//   returns one beat on rsp_ carrying the texel at the rippled source
//   coordinate. Beats of both kinds are handled strictly in order, so a read
//   sees every load accepted before it.
//   Pipeline: stage 1 forms the four 13-bit ripple phases, stage 2 turns them
//   into offsets and the source address, the store access registers the
//   fetched texel as the output stage, which drives rsp_tvalid. One beat per
//   cycle is accepted while rsp_tready stays high, set by the single store
//   port taking one load or one fetch per cycle.
//   Stalls: when rsp_tready is low the output holds; earlier stages keep
//   filling any empty slot, and req_tready drops only once every stage ahead
//   is full. Nothing is lost or repeated.
//   Reset clears the stage valid bits only. The texture store has no reset
//   and no clearing pass: load a texel before reading it.
// ----------------------------------------------------------------------------
module sine_ripple_texture_warp_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [11:0] pixel_index, [19:12] texel_value, [29:20] frame_tick, [31:30] zero
   input  logic [31:0] req_tdata,
   // [0] operation
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] warped_texel
   output logic [7:0]  rsp_tdata
);

   localparam int CW = srtw_pkg::COORD_W;
   localparam int PW = srtw_pkg::PHASE_W;
   localparam int TW = srtw_pkg::TEXEL_W;
   localparam int AW = srtw_pkg::ADDR_W;

   // input fields
   logic [AW-1:0]               req_index;
   logic [TW-1:0]               req_texel;
   logic [srtw_pkg::TICK_W-1:0] req_tick;
   logic [CW-1:0]               req_x;
   logic [CW-1:0]               req_y;

   assign req_index = req_tdata[11:0];
   assign req_texel = req_tdata[19:12];
   assign req_tick  = req_tdata[29:20];
   assign req_x     = req_index[CW-1:0];
   assign req_y     = req_index[2*CW-1:CW];

   // stage advance, from the output back
   logic adv1, adv2, adv3;

   // stage 1: phases
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_op_ff;
   logic [TW-1:0] s1_texel_ff;
   logic [CW-1:0] s1_x_ff, s1_y_ff;
   logic [PW-1:0] s1_phx0_ff, s1_phx1_ff, s1_phy0_ff, s1_phy1_ff;
   logic [PW-1:0] s1_phx0_in, s1_phx1_in, s1_phy0_in, s1_phy1_in;

   // stage 2: store address
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_op_ff;
   logic [TW-1:0] s2_texel_ff;
   logic [AW-1:0] s2_addr_ff, s2_addr_in;

   // stage 3: fetched texel
   logic          s3_valid_ff, s3_valid_in;

   // store port
   logic          ram_en;
   logic          ram_we;
   logic [TW-1:0] ram_rdata;

   assign adv3 = !s3_valid_ff || rsp_tready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_tready = adv1;

   // Phases mod 8192: y*128, x*256, x*128, y*256 and the tick products all wrap in 13 bits.
   always_comb begin
      s1_phx0_in = PW'({req_y, 7'b0})
                 + PW'(req_tick * srtw_pkg::TICK_RATE_X0)
                 + PW'(srtw_pkg::PHASE_BASE_X0);
      s1_phx1_in = PW'({req_x, 8'b0})
                 + PW'(req_tick * srtw_pkg::TICK_RATE_X1)
                 + PW'(srtw_pkg::PHASE_BASE_X1);
      s1_phy0_in = PW'({req_x, 7'b0})
                 + PW'(req_tick * srtw_pkg::TICK_RATE_Y0)
                 + PW'(srtw_pkg::PHASE_BASE_Y0);
      s1_phy1_in = PW'({req_y, 8'b0})
                 + PW'(req_tick * srtw_pkg::TICK_RATE_Y1)
                 + PW'(srtw_pkg::PHASE_BASE_Y1);
   end

   assign s1_valid_in = adv1 ? req_tvalid : s1_valid_ff;

   // Source coordinates add both sign-extended offsets and wrap in 6 bits.
   // Loads keep their own address.
   always_comb begin
      srtw_pkg::ripple_type rx0, rx1, ry0, ry1;
      logic [CW-1:0] sx, sy;
      rx0 = srtw_pkg::ripple_term(s1_phx0_ff);
      rx1 = srtw_pkg::ripple_term(s1_phx1_ff);
      ry0 = srtw_pkg::ripple_term(s1_phy0_ff);
      ry1 = srtw_pkg::ripple_term(s1_phy1_ff);
      sx = s1_x_ff + {{(CW-2){rx0[1]}}, rx0} + {{(CW-2){rx1[1]}}, rx1};
      sy = s1_y_ff + {{(CW-2){ry0[1]}}, ry0} + {{(CW-2){ry1[1]}}, ry1};
      if (s1_op_ff == srtw_pkg::OP_READ) begin
         s2_addr_in = {sy, sx};
      end else begin
         s2_addr_in = {s1_y_ff, s1_x_ff};
      end
   end

   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   // Loads leave the pipe at the store; only reads take the output slot.
   assign ram_en      = s2_valid_ff && adv3;
   assign ram_we      = (s2_op_ff == srtw_pkg::OP_LOAD);
   assign s3_valid_in = adv3 ? (s2_valid_ff && s2_op_ff == srtw_pkg::OP_READ)
                             : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_op_ff    <= req_tuser;
         s1_texel_ff <= req_texel;
         s1_x_ff     <= req_x;
         s1_y_ff     <= req_y;
         s1_phx0_ff  <= s1_phx0_in;
         s1_phx1_ff  <= s1_phx1_in;
         s1_phy0_ff  <= s1_phy0_in;
         s1_phy1_ff  <= s1_phy1_in;
      end
      if (adv2) begin
         s2_op_ff    <= s1_op_ff;
         s2_texel_ff <= s1_texel_ff;
         s2_addr_ff  <= s2_addr_in;
      end
   end

   srtw_ram #(
      .WIDTH (TW),
      .DEPTH (srtw_pkg::FLAT_TEXELS)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (s2_addr_ff),
      .wdata (s2_texel_ff),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = ram_rdata;

`ifndef SYNTHESIS
   // an accepted beat always lands in stage 1
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted beat did not reach stage 1");

   // a blocked stage 2 keeps its address
   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !adv2 |=> s2_valid_ff && $stable(s2_addr_ff))
      else $error("stage 2 changed while blocked");

   // a result appears only behind a read leaving stage 2
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s2_valid_ff && s2_op_ff == srtw_pkg::OP_READ))
      else $error("result without a read");

   // an empty stage 1 never back-pressures the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input stalled with stage 1 empty");
`endif

endmodule
